// ----- rtl/istk_pkg.sv -----
`timescale 1ns / 1ps

package istk_pkg;

    localparam logic [2:0] CMD_PUSH    = 3'd0;
    localparam logic [2:0] CMD_POP     = 3'd1;
    localparam logic [2:0] CMD_PEEK    = 3'd2;
    localparam logic [2:0] CMD_POPRET  = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;
    localparam logic [2:0] CMD_SUM     = 3'd5;
    localparam logic [2:0] CMD_PRODUCT = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       entry_count;
    } t_out_item;

    // Control of the shared accumulate unit
    typedef struct packed {
        logic load;   // start from the identity of the operation
        logic step;   // fold one operand into the accumulator
        logic mul;    // product when set, sum otherwise
    } t_alu_ctrl;

endpackage

// ----- rtl/istk_alu.sv -----
`timescale 1ns / 1ps

module istk_alu (
    input  logic                                i_clk,
    input  istk_pkg::t_alu_ctrl                 i_ctrl,
    input  logic [istk_pkg::DATA_W-1:0]         i_operand,
    output logic [istk_pkg::DATA_W-1:0]         o_acc
);

    logic [istk_pkg::DATA_W-1:0] r_acc;
    logic [istk_pkg::DATA_W-1:0] n_acc;
    logic [istk_pkg::DATA_W-1:0] w_prod;
    logic [istk_pkg::DATA_W-1:0] w_sum;

    // Low half of the product and the sum wrap the same way signed or unsigned
    assign w_prod = r_acc * i_operand;
    assign w_sum  = r_acc + i_operand;

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.load) begin
            n_acc = i_ctrl.mul ? istk_pkg::DATA_W'(1) : '0;
        end else if (i_ctrl.step) begin
            n_acc = i_ctrl.mul ? w_prod : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ----- rtl/integer_stack_with_reductions_top.sv -----
`timescale 1ns / 1ps

// LIFO stack of signed 32-bit integers with sum and product collapse.
// Input channel: i_in_valid / o_in_stall carry one command transaction
// (command, push_value). Output channel: o_out_valid / i_out_stall return
// exactly one result transaction (result_value, status, entry_count) per
// command, in order.
// o_out_valid rises once the result loads from S_DONE into the output
// register: push, pop, clear and the unused code go from S_IDLE straight
// to S_DONE; peek and pop-and-return on a non-empty stack first pass S_READ
// (one registered read of the stack memory); sum and product pass S_WB,
// after S_RED on a non-empty stack, where the single accumulate unit folds
// one entry per cycle. One command is in flight at a time; the next is
// taken the cycle after its result enters the output register.
// A stalled result holds in the output register; the finished command
// then waits and no new command is taken until the register frees.
// Reset empties the stack and drops any pending result; the stack memory
// itself is not cleared and needs no clearing pass.
module integer_stack_with_reductions_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  istk_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output istk_pkg::t_out_item   o_out_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_RED  = 5'b00100,
        S_WB   = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                           r_state, n_state;
    logic [2:0]                       r_cmd, n_cmd;
    logic [CW-1:0]                    r_count, n_count;
    logic [AW-1:0]                    r_idx, n_idx;
    logic [istk_pkg::DATA_W-1:0]      r_res, n_res;
    logic [1:0]                       r_status, n_status;
    logic                             r_out_valid, n_out_valid;
    istk_pkg::t_out_item              r_out, n_out;

    logic [istk_pkg::DATA_W-1:0]      r_mem [STACK_DEPTH];
    logic [istk_pkg::DATA_W-1:0]      r_rd_data;
    logic [AW-1:0]                    w_rd_addr;
    logic                             w_we;
    logic [AW-1:0]                    w_waddr;
    logic [istk_pkg::DATA_W-1:0]      w_wdata;

    istk_pkg::t_alu_ctrl              w_alu_ctrl;
    logic [istk_pkg::DATA_W-1:0]      w_acc;

    logic                             w_empty;
    logic                             w_full;
    logic [CW+6:0]                    w_cnt_ext;

    assign w_empty   = (r_count == '0);
    assign w_full    = (r_count >= CW'(STACK_DEPTH));
    assign w_cnt_ext = (CW + 7)'(r_count);

    istk_alu u_alu (
        .i_clk     (i_clk),
        .i_ctrl    (w_alu_ctrl),
        .i_operand (r_rd_data),
        .o_acc     (w_acc)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_count     = r_count;
        n_idx       = r_idx;
        n_res       = r_res;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_rd_addr   = '0;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = w_acc;
        w_alu_ctrl  = '0;

        // drop a taken result; a new one may load below in the same cycle
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_data.command;
                    n_res    = '0;
                    n_status = istk_pkg::ST_OK;
                    n_state  = S_DONE;
                    unique case (i_in_data.command)
                        istk_pkg::CMD_PUSH: begin
                            if (w_full) begin
                                n_status = istk_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = AW'(r_count);
                                w_wdata = i_in_data.push_value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        istk_pkg::CMD_POP: begin
                            if (w_empty) begin
                                n_status = istk_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        istk_pkg::CMD_PEEK, istk_pkg::CMD_POPRET: begin
                            if (w_empty) begin
                                n_status = istk_pkg::ST_EMPTY;
                            end else begin
                                w_rd_addr = AW'(r_count - CW'(1));
                                n_state   = S_READ;
                            end
                        end
                        istk_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        istk_pkg::CMD_SUM, istk_pkg::CMD_PRODUCT: begin
                            w_alu_ctrl.load = 1'b1;
                            w_alu_ctrl.mul  = (i_in_data.command == istk_pkg::CMD_PRODUCT);
                            n_idx           = '0;
                            w_rd_addr       = '0;
                            n_state         = w_empty ? S_WB : S_RED;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res = r_rd_data;
                if (r_cmd == istk_pkg::CMD_POPRET) begin
                    n_count = r_count - CW'(1);
                end
                n_state = S_DONE;
            end
            S_RED: begin
                w_alu_ctrl.step = 1'b1;
                w_alu_ctrl.mul  = (r_cmd == istk_pkg::CMD_PRODUCT);
                if (CW'(r_idx) + CW'(1) == r_count) begin
                    n_state = S_WB;
                end else begin
                    // fetch the next entry while this one folds in
                    n_idx     = r_idx + AW'(1);
                    w_rd_addr = r_idx + AW'(1);
                end
            end
            S_WB: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = w_acc;
                n_count = CW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid        = 1'b1;
                    n_out.result_value = r_res;
                    n_out.status       = r_status;
                    n_out.entry_count  = w_cnt_ext[6:0];
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_res    <= n_res;
        r_status <= n_status;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/istk_chk.sv -----
`timescale 1ns / 1ps

module istk_chk #(
    parameter int STACK_DEPTH = 64
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input istk_pkg::t_in_item    i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input istk_pkg::t_out_item   o_out_data
);

    // A stalled result transaction holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or vanished");

    // One command in flight: never two acceptances on consecutive edges
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second command taken while one is in flight");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((STACK_DEPTH > 127) ||
                         (int'(o_out_data.entry_count) <= STACK_DEPTH)))
        else $error("entry count above stack depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == istk_pkg::ST_FULL)) |->
            (o_out_data.entry_count == 7'(STACK_DEPTH)))
        else $error("full status with stack not full");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == istk_pkg::ST_EMPTY)) |->
            ((o_out_data.entry_count == '0) && (o_out_data.result_value == '0)))
        else $error("empty status with nonzero count or value");

endmodule

bind integer_stack_with_reductions_top istk_chk #(
    .STACK_DEPTH (STACK_DEPTH)
) u_istk_chk (.*);
